// ===== hdl/bpfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit-packed frame builder package
// Command format passed from the front end to the byte sequencer, and the
// fixed frame layout constants.
// ----------------------------------------------------------------------------
package bpfb_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam int IDX_W = 4;

  // Byte indexes within one command.
  localparam logic [IDX_W-1:0] HDR_LEN_BYTE      = 4'd7;
  localparam logic [IDX_W-1:0] HDR_LAST          = 4'd7;
  localparam logic [IDX_W-1:0] HDR_TRAIL_FIRST   = 4'd8;
  localparam logic [IDX_W-1:0] HDR_TRAIL_LAST    = 4'd12;
  localparam logic [IDX_W-1:0] PAY_LAST          = 4'd0;
  localparam logic [IDX_W-1:0] PAY_TRAIL_FIRST   = 4'd1;
  localparam logic [IDX_W-1:0] PAY_TRAIL_LAST    = 4'd5;

  typedef struct packed {
    logic        is_payload;  // 0: header command, 1: payload byte command
    logic        trail;       // trailer follows this command
    logic [6:0]  pend;        // pending stream bits ahead of the payload byte
    logic [7:0]  data;        // payload byte
    logic [10:0] len;         // saturated payload length
    logic [3:0]  op;
    logic [2:0]  rc;
    logic [31:0] session;
  } cmd_t;

endpackage

// ===== hdl/bpfb_front.sv =====
// ----------------------------------------------------------------------------
// Bit-packed frame builder front end
// Accepts input items, tracks the open frame and turns each item into a
// command for the byte sequencer. Stray payload items are dropped here.
// ----------------------------------------------------------------------------
module bpfb_front #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              func,
  input  logic [3:0]        opcode,
  input  logic [2:0]        response_code,
  input  logic [10:0]       payload_length,
  input  logic [31:0]       session_ident,
  input  logic [7:0]        payload_byte,
  output logic              cmd_push,
  output bpfb_pkg::cmd_t    cmd
);

  localparam logic [16:0] MaxPay = 17'(MAX_PAYLOAD);

  logic        frame_open;
  logic [6:0]  pending_bits;
  logic [10:0] bytes_remaining;
  logic [31:0] held_session;

  logic        frame_open_next;
  logic [6:0]  pending_bits_next;
  logic [10:0] bytes_remaining_next;
  logic [31:0] held_session_next;

  logic [10:0] len_sat;
  logic        last_byte;

  always_comb begin
    if ({6'b0, payload_length} > MaxPay) begin
      len_sat = MaxPay[10:0];
    end else begin
      len_sat = payload_length;
    end
  end

  assign last_byte = (bytes_remaining == 11'd1);

  always_comb begin
    frame_open_next      = frame_open;
    pending_bits_next    = pending_bits;
    bytes_remaining_next = bytes_remaining;
    held_session_next    = held_session;
    cmd_push             = 1'b0;
    cmd                  = '0;
    cmd.op               = opcode;
    cmd.rc               = response_code;
    cmd.len              = len_sat;
    cmd.data             = payload_byte;
    cmd.pend             = pending_bits;
    cmd.session          = held_session;
    if (accept) begin
      if (!func) begin
        cmd_push             = 1'b1;
        cmd.session          = session_ident;
        held_session_next    = session_ident;
        bytes_remaining_next = len_sat;
        if (len_sat == 11'd0) begin
          cmd.trail         = 1'b1;
          frame_open_next   = 1'b0;
          pending_bits_next = 7'd0;
        end else begin
          frame_open_next   = 1'b1;
          // The low seven length bits are sent MSB first and stay pending.
          pending_bits_next = {len_sat[0], len_sat[1], len_sat[2], len_sat[3],
                               len_sat[4], len_sat[5], len_sat[6]};
        end
      end else if (frame_open) begin
        cmd_push             = 1'b1;
        cmd.is_payload       = 1'b1;
        cmd.trail            = last_byte;
        bytes_remaining_next = bytes_remaining - 11'd1;
        if (last_byte) begin
          frame_open_next   = 1'b0;
          pending_bits_next = 7'd0;
        end else begin
          pending_bits_next = payload_byte[7:1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      pending_bits    <= 7'd0;
      bytes_remaining <= 11'd0;
      held_session    <= 32'd0;
    end else begin
      frame_open      <= frame_open_next;
      pending_bits    <= pending_bits_next;
      bytes_remaining <= bytes_remaining_next;
      held_session    <= held_session_next;
    end
  end

endmodule

// ===== hdl/bpfb_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// Bit-packed frame builder command queue
// Short first-in first-out queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module bpfb_cmd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bpfb_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output bpfb_pkg::cmd_t    head
);

  localparam int PtrW = bpfb_pkg::QUEUE_PTR_W;
  localparam logic [PtrW:0] Depth = (PtrW + 1)'(bpfb_pkg::QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(bpfb_pkg::QUEUE_DEPTH - 1);

  bpfb_pkg::cmd_t slots [bpfb_pkg::QUEUE_DEPTH];

  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == Depth);
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + {{PtrW{1'b0}}, do_push} - {{PtrW{1'b0}}, do_pop};
    end
  end

endmodule

// ===== hdl/bpfb_back.sv =====
// ----------------------------------------------------------------------------
// Bit-packed frame builder byte sequencer
// Walks the command at the queue head one frame byte per cycle while the output
// register is free or being taken, and holds the oldest byte there until it is taken.
// ----------------------------------------------------------------------------
module bpfb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  input  bpfb_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        frame_byte,
  output logic              frame_end
);

  localparam int IdxW = bpfb_pkg::IDX_W;

  logic [IdxW-1:0] idx;
  logic            out_valid;
  logic            load;
  logic [IdxW-1:0] last_idx;
  logic            at_last;
  logic [IdxW-1:0] trail_first;
  logic [IdxW-1:0] trail_off;
  logic [6:0]      trail_pend;
  logic [7:0]      trail_byte;
  logic [7:0]      byte_val;

  assign empty = !out_valid;
  assign load  = !cmd_empty && (!out_valid || pop);

  always_comb begin
    if (cmd.is_payload) begin
      last_idx    = cmd.trail ? bpfb_pkg::PAY_TRAIL_LAST : bpfb_pkg::PAY_LAST;
      trail_first = bpfb_pkg::PAY_TRAIL_FIRST;
      trail_pend  = cmd.data[7:1];
    end else begin
      last_idx    = cmd.trail ? bpfb_pkg::HDR_TRAIL_LAST : bpfb_pkg::HDR_LAST;
      trail_first = bpfb_pkg::HDR_TRAIL_FIRST;
      trail_pend  = 7'd0;
    end
  end

  assign at_last   = (idx == last_idx);
  assign trail_off = idx - trail_first;
  assign cmd_pop   = load && at_last;

  // Trailer: 32 session bits after the pending bits, then one zero bit.
  always_comb begin
    case (trail_off[2:0])
      3'd0:    trail_byte = {cmd.session[0], trail_pend};
      3'd1:    trail_byte = cmd.session[8:1];
      3'd2:    trail_byte = cmd.session[16:9];
      3'd3:    trail_byte = cmd.session[24:17];
      default: trail_byte = {1'b0, cmd.session[31:25]};
    endcase
  end

  always_comb begin
    if (cmd.is_payload) begin
      if (idx == '0) begin
        byte_val = {cmd.data[0], cmd.pend};
      end else begin
        byte_val = trail_byte;
      end
    end else if (idx == '0) begin
      byte_val = {1'b0, cmd.rc, cmd.op};
    end else if (idx == bpfb_pkg::HDR_LEN_BYTE) begin
      byte_val = {cmd.len[7], cmd.len[8], cmd.len[9], cmd.len[10], 4'b0};
    end else if (idx >= bpfb_pkg::HDR_TRAIL_FIRST) begin
      byte_val = trail_byte;
    end else begin
      byte_val = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte <= byte_val;
      frame_end  <= at_last && cmd.trail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= at_last ? '0 : idx + 1'b1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/bit_packed_frame_builder.sv =====
// ----------------------------------------------------------------------------
// Bit-packed frame builder
// Builds bit-packed message frames and emits them one byte at a time.
// ----------------------------------------------------------------------------
// Input items are written like a queue: an item transfers on a clock edge
// with push high and full low. A header item (func 0) opens a frame and
// yields 8 bytes, or 13 bytes with the trailer when its length is zero.
// Each payload item (func 1) yields one byte; the last one of a frame yields
// 6 bytes including the trailer. Payload items with no open frame are dropped.
// Results are read like a queue: while empty is low, frame_byte and frame_end
// show the oldest byte, which transfers on an edge with pop high.
// The command for an item goes into the command queue; its first byte is then
// loaded into the output register. The byte sequencer produces one byte per
// cycle while pop keeps up, so payload items stream at one per cycle; while
// header or trailer bursts drain, the four-entry command queue raises full.
// When pop stays low, the output register holds its byte and the queue
// backs up to full. Synchronous reset closes any open frame and empties both
// the command queue and the output register.
// ----------------------------------------------------------------------------
module bit_packed_frame_builder #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [3:0]  opcode,
  input  logic [2:0]  response_code,
  input  logic [10:0] payload_length,
  input  logic [31:0] session_ident,
  input  logic [7:0]  payload_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte,
  output logic        frame_end
);

  logic           accept;
  logic           cmd_push;
  bpfb_pkg::cmd_t cmd_in;
  bpfb_pkg::cmd_t cmd_head;
  logic           cmd_pop;
  logic           cmd_empty;

  assign accept = push && !full;

  bpfb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .func          (func),
    .opcode        (opcode),
    .response_code (response_code),
    .payload_length(payload_length),
    .session_ident (session_ident),
    .payload_byte  (payload_byte),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  bpfb_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .push_cmd(cmd_in),
    .pop     (cmd_pop),
    .full    (full),
    .empty   (cmd_empty),
    .head    (cmd_head)
  );

  bpfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .frame_byte(frame_byte),
    .frame_end (frame_end)
  );

endmodule
